// File: rtl/gvpe_pkg.sv
// shared types, constants and gf(2^8) arithmetic for the vandermonde parity encoder
// used by gvpe_lane, gvpe_merge and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gvpe_pkg;

    localparam int DATA_LANES   = 8;
    localparam int PARITY_LANES = 4;
    localparam int OUT_ROWS     = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int DCOUNT_W     = 4;
    localparam int PCOUNT_W     = 3;

    localparam logic [7:0] GF_POLY_LOW = 8'h1D;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_COUNT = CFG_IDX_W'(1);

    localparam logic [DCOUNT_W-1:0] DCOUNT_RESET = DCOUNT_W'(4);
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(2);

    typedef logic [7:0] t_byte;
    typedef logic [PARITY_LANES-1:0][7:0] t_rows;
    typedef logic [OUT_ROWS-1:0][7:0] t_out_rows;

    typedef struct packed {
        logic                    lane_en;
        logic [PARITY_LANES-1:0] row_en;
    } t_lane_ctl;

    function automatic t_byte gf_mul(t_byte a, t_byte b);
        t_byte acc;
        t_byte x;
        acc = '0;
        x   = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

    function automatic t_byte gf_coeff(int lane, int row);
        t_byte base;
        t_byte r;
        base = 8'(lane + 1);
        r    = 8'h01;
        for (int k = 0; k < PARITY_LANES; k++) begin
            if (k < row) begin
                r = gf_mul(r, base);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gvpe_lane.sv
// one data lane: multiplies its byte by the coefficient of every enabled parity row
// depends on gvpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module gvpe_lane
    import gvpe_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  wire t_lane_ctl i_ctl,
    input  wire t_byte     i_data,
    input  wire t_rows     i_coeff,
    output t_rows          o_prod
);

    t_rows r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < PARITY_LANES; i++) begin
                r_prod[i] <= (i_ctl.lane_en && i_ctl.row_en[i]) ?
                             gf_mul(i_coeff[i], i_data) : 8'h00;
            end
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/gvpe_merge.sv
// merging stage: xor of the lane products per row into the output register
// depends on gvpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module gvpe_merge
    import gvpe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_rows i_prod [DATA_LANES],
    input  wire logic  i_end,
    output t_out_rows  o_parity,
    output logic       o_end
);

    t_out_rows n_parity;
    t_out_rows r_parity;
    logic      r_end;

    for (genvar gi = 0; gi < OUT_ROWS; gi++) begin : g_row
        if (gi < PARITY_LANES) begin : g_used
            always_comb begin
                n_parity[gi] = 8'h00;
                for (int j = 0; j < DATA_LANES; j++) begin
                    n_parity[gi] = n_parity[gi] ^ i_prod[j][gi];
                end
            end
        end else begin : g_unused
            assign n_parity[gi] = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_parity <= n_parity;
            r_end    <= i_end;
        end
    end

    assign o_parity = r_parity;
    assign o_end    = r_end;

endmodule

`default_nettype wire

// File: rtl/gf256_vandermonde_parity_encoder.sv
// top level of the gf(2^8) vandermonde parity encoder: handshake, config, lanes, merge
// depends on gvpe_pkg, gvpe_lane and gvpe_merge
//
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_data_byte_0..7, i_chunk_end_in
// output    out        o_valid / i_ready    o_parity_byte_0..3, o_chunk_end_out
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one word per cycle sustained while i_ready holds; a result passes the lane product register, then the merge register
// the two stages advance independently, so a word is taken while a result waits
// reset clears the stage valids and loads data_count 4, parity_count 2
// a stalled output holds its word; the lane stage still takes one more word if it is empty
`timescale 1ns / 1ps
`default_nettype none

module gf256_vandermonde_parity_encoder
    import gvpe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_data_byte_0,
    input  wire logic [7:0]            i_data_byte_1,
    input  wire logic [7:0]            i_data_byte_2,
    input  wire logic [7:0]            i_data_byte_3,
    input  wire logic [7:0]            i_data_byte_4,
    input  wire logic [7:0]            i_data_byte_5,
    input  wire logic [7:0]            i_data_byte_6,
    input  wire logic [7:0]            i_data_byte_7,
    input  wire logic                  i_chunk_end_in,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_parity_byte_0,
    output logic [7:0]                 o_parity_byte_1,
    output logic [7:0]                 o_parity_byte_2,
    output logic [7:0]                 o_parity_byte_3,
    output logic                       o_chunk_end_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [DCOUNT_W-1:0] r_data_count;
    logic [PCOUNT_W-1:0] r_parity_count;
    logic                r_v1;
    logic                r_v2;
    logic                n_v1;
    logic                n_v2;
    logic                r_end1;
    logic                in_acc;
    logic                adv2;
    t_byte               data_in [8];
    t_rows               coeff   [DATA_LANES];
    t_lane_ctl           ctl     [DATA_LANES];
    t_rows               prod    [DATA_LANES];
    t_out_rows           parity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_count   <= DCOUNT_RESET;
            r_parity_count <= PCOUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DATA_COUNT:   r_data_count   <= i_cfg_data[DCOUNT_W-1:0];
                REG_PARITY_COUNT: r_parity_count <= i_cfg_data[PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv2    = r_v1 && (!r_v2 || i_ready);
    assign o_ready = !r_v1 || !r_v2 || i_ready;
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        n_v1 = r_v1;
        if (in_acc) begin
            n_v1 = 1'b1;
        end else if (adv2) begin
            n_v1 = 1'b0;
        end
        n_v2 = r_v2;
        if (adv2) begin
            n_v2 = 1'b1;
        end else if (i_ready) begin
            n_v2 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_end1 <= i_chunk_end_in;
        end
    end

    assign data_in[0] = i_data_byte_0;
    assign data_in[1] = i_data_byte_1;
    assign data_in[2] = i_data_byte_2;
    assign data_in[3] = i_data_byte_3;
    assign data_in[4] = i_data_byte_4;
    assign data_in[5] = i_data_byte_5;
    assign data_in[6] = i_data_byte_6;
    assign data_in[7] = i_data_byte_7;

    for (genvar gj = 0; gj < DATA_LANES; gj++) begin : g_lane
        for (genvar gi = 0; gi < PARITY_LANES; gi++) begin : g_coeff
            assign coeff[gj][gi]      = gf_coeff(gj, gi);
            assign ctl[gj].row_en[gi] = (PCOUNT_W'(gi) < r_parity_count);
        end
        assign ctl[gj].lane_en = (DCOUNT_W'(gj) < r_data_count);

        gvpe_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (in_acc),
            .i_ctl   (ctl[gj]),
            .i_data  (data_in[gj]),
            .i_coeff (coeff[gj]),
            .o_prod  (prod[gj])
        );
    end

    gvpe_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (adv2),
        .i_prod   (prod),
        .i_end    (r_end1),
        .o_parity (parity),
        .o_end    (o_chunk_end_out)
    );

    assign o_valid         = r_v2;
    assign o_parity_byte_0 = parity[0];
    assign o_parity_byte_1 = parity[1];
    assign o_parity_byte_2 = parity[2];
    assign o_parity_byte_3 = parity[3];

endmodule

`default_nettype wire
